// ===== hw/rtl/vtp_pkg.sv =====
// vtp_pkg: shared types and constants for the vector_to_polar block
// fixed-point formats, cordic arctangent table, angle and quadrant codes
// no dependencies

package vtp_pkg;

    // fixed-point layout of the cordic datapath
    localparam int FRAC      = 28;
    localparam int ZSHIFT    = 12;
    localparam int ZW        = 27;
    localparam int MAX_STEPS = 24;

    // result field widths
    localparam int MAG_W       = 16;
    localparam int ANG_W       = 16;
    localparam int QUAD_W      = 3;
    localparam int BASE_W      = 14;
    localparam int OUT_DATA_W  = 40;
    localparam int RESULT_W    = MAG_W + ANG_W + QUAD_W;

    // atan(2^-i) in units of 2^-12 of 1/128 degree
    localparam int ATAN_UNITS [MAX_STEPS] = '{
        23592960, 13927738, 7359034, 3735561, 1875029, 938429, 469329, 234679,
        117341, 58671, 29335, 14668, 7334, 3667, 1833, 917,
        458, 229, 115, 57, 29, 14, 7, 4
    };

    // 1/K of an infinite cordic run, Q32
    localparam logic [63:0] INVK_INF_Q32 = 64'd2608131496;

    localparam logic [ANG_W-1:0] QUARTER_UNITS = 16'd11520;
    localparam logic [ANG_W-1:0] HALF_UNITS    = 16'd23040;
    localparam logic [ANG_W-1:0] FULL_UNITS    = 16'd46080;
    localparam logic [MAG_W-1:0] MAG_MAX       = 16'hFFFF;

    localparam logic [QUAD_W-1:0] QUAD_AXIS = 3'd0;
    localparam logic [QUAD_W-1:0] QUAD_1    = 3'd1;
    localparam logic [QUAD_W-1:0] QUAD_2    = 3'd2;
    localparam logic [QUAD_W-1:0] QUAD_3    = 3'd3;
    localparam logic [QUAD_W-1:0] QUAD_4    = 3'd4;

    // per-item sideband carried alongside the cordic chain
    typedef struct packed {
        logic             direct;  // zero or on-axis vector, result known at entry
        logic             xn;
        logic             yn;
        logic [MAG_W-1:0] dmag;
        logic [ANG_W-1:0] dang;
    } t_side;

    typedef struct packed {
        logic [QUAD_W-1:0] quadrant_code;
        logic [ANG_W-1:0]  angle;
        logic [MAG_W-1:0]  magnitude;
    } t_result;

endpackage

// ===== hw/rtl/vtp_cell.sv =====
// vtp_cell: one cordic vectoring iteration with its pipeline register
// rotates (x, y) by +/-atan(2^-STAGE) and updates the angle accumulator
// depends on vtp_pkg

module vtp_cell
    import vtp_pkg::*;
#(
    parameter int W     = 46,
    parameter int STAGE = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  t_side               i_side,
    output logic                o_valid,
    output logic signed [W-1:0] o_x,
    output logic signed [W-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output t_side               o_side
);

    localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_UNITS[STAGE]);

    logic                 r_valid;
    logic signed [W-1:0]  r_x, r_y;
    logic signed [ZW-1:0] r_z;
    t_side                r_side;

    logic signed [W-1:0]  n_x, n_y;
    logic signed [ZW-1:0] n_z;

    always_comb begin
        // y below zero: rotate counterclockwise, else clockwise
        if (i_y[W-1]) begin
            n_x = i_x - (i_y >>> STAGE);
            n_y = i_y + (i_x >>> STAGE);
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + (i_y >>> STAGE);
            n_y = i_y - (i_x >>> STAGE);
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

// ===== hw/rtl/vtp_post.sv =====
// vtp_post: gain compensation, angle rounding and quadrant reflection
// one register stage after the multipliers, result logic after it
// depends on vtp_pkg

module vtp_post
    import vtp_pkg::*;
#(
    parameter int W          = 46,
    parameter int ITERATIONS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [W-1:0]  i_x,
    input  logic signed [ZW-1:0] i_z,
    input  t_side                i_side,
    output logic                 o_valid,
    output t_result              o_result
);

    localparam logic [31:0] INVK =
        32'(INVK_INF_Q32 + ((INVK_INF_Q32 * 64'd2 / 64'd3) >> (2 * ITERATIONS)));
    localparam logic [ZW-1:0] ZMAX     = ZW'(QUARTER_UNITS) << ZSHIFT;
    localparam logic [ZW-1:0] ZROUND   = ZW'(1) << (ZSHIFT - 1);
    localparam logic [W:0]    MAG_HALF = (W + 1)'(1) << (FRAC - 1);

    logic            r_valid;
    logic [W-1:0]    r_prod_hi;
    logic [31:0]     r_prod_lo;
    logic [BASE_W-1:0] r_base;
    t_side           r_side;

    logic [W-33:0]   x_hi;
    logic [31:0]     x_lo;
    logic [W-1:0]    prod_hi;
    logic [63:0]     prod_lo;
    logic [ZW-1:0]   z_clamp;
    logic [ZW-1:0]   z_round;

    always_comb begin
        x_hi    = i_x[W-1:32];
        x_lo    = i_x[31:0];
        prod_hi = W'(x_hi) * W'(INVK);
        prod_lo = 64'(x_lo) * 64'(INVK);
        if (i_z[ZW-1]) begin
            z_clamp = '0;
        end else if (ZW'(i_z) > ZMAX) begin
            z_clamp = ZMAX;
        end else begin
            z_clamp = ZW'(i_z);
        end
        z_round = z_clamp + ZROUND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_hi <= prod_hi;
            r_prod_lo <= prod_lo[63:32];
            r_base    <= z_round[ZSHIFT+BASE_W-1:ZSHIFT];
            r_side    <= i_side;
        end
    end

    logic [W:0]     mag_sum;
    logic [W+16:0]  mag_q;
    logic [MAG_W-1:0] mag_sat;
    logic [ANG_W-1:0] base_ext;
    logic [ANG_W-1:0] ang_q4;

    always_comb begin
        mag_sum  = (W + 1)'(r_prod_hi) + (W + 1)'(r_prod_lo) + MAG_HALF;
        mag_q    = (W + 17)'(mag_sum) >> FRAC;
        mag_sat  = (mag_q > (W + 17)'(MAG_MAX)) ? MAG_MAX : mag_q[MAG_W-1:0];
        base_ext = ANG_W'(r_base);
        // a zero base in the fourth quadrant wraps to zero
        ang_q4   = (base_ext == '0) ? '0 : (FULL_UNITS - base_ext);

        if (r_side.direct) begin
            o_result.magnitude     = r_side.dmag;
            o_result.angle         = r_side.dang;
            o_result.quadrant_code = QUAD_AXIS;
        end else begin
            o_result.magnitude = mag_sat;
            case ({r_side.xn, r_side.yn})
                2'b01: begin
                    o_result.quadrant_code = QUAD_1;
                    o_result.angle         = base_ext;
                end
                2'b11: begin
                    o_result.quadrant_code = QUAD_2;
                    o_result.angle         = HALF_UNITS - base_ext;
                end
                2'b10: begin
                    o_result.quadrant_code = QUAD_3;
                    o_result.angle         = HALF_UNITS + base_ext;
                end
                default: begin
                    o_result.quadrant_code = QUAD_4;
                    o_result.angle         = ang_q4;
                end
            endcase
        end
    end

    assign o_valid = r_valid;

endmodule

// ===== hw/rtl/vector_to_polar.sv =====
// vector_to_polar: top level, cordic magnitude and atan2 of a screen vector
// input decode, a chain of vtp_cell iterations, vtp_post and an output skid
// depends on vtp_pkg, vtp_cell, vtp_post
//
//  channel   dir  fields (lsb first)                          transfer when
//  s_axis    in   tdata: x_coord, y_coord                     tvalid && tready
//  m_axis    out  tdata: magnitude, angle, quadrant_code      tvalid && tready
//
//  one vector per cycle sustained while the skid register is empty; a vector passes the
//  entry register, one cell per iteration, the product register and the output register
//  reset clears every valid bit, payload registers are not reset
//  a result not taken sits in the output register while the pipe keeps going;
//  the next one parks in the skid register, which drops s_axis_tready and
//  freezes the whole chain until the output register frees up

module vector_to_polar
    import vtp_pkg::*;
#(
    parameter int ITERATIONS  = 16,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  logic [((2 * COORD_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,   // x_coord, y_coord
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    output logic [OUT_DATA_W-1:0]                      m_axis_tdata    // magnitude, angle, quadrant_code
);

    localparam int W         = COORD_WIDTH + FRAC + 2;
    localparam int CW        = COORD_WIDTH;

    logic en;

    // ---------------- entry decode ----------------
    logic [CW-1:0]   x_raw, y_raw;
    logic            xn, yn, xnz, ynz;
    logic [CW-1:0]   ax, ay;
    logic [CW+15:0]  ax_ext, ay_ext;
    logic [MAG_W-1:0] ax_sat, ay_sat;
    t_side           side_in;

    always_comb begin
        x_raw  = s_axis_tdata[CW-1:0];
        y_raw  = s_axis_tdata[2*CW-1:CW];
        xn     = x_raw[CW-1];
        yn     = y_raw[CW-1];
        xnz    = |x_raw;
        ynz    = |y_raw;
        ax     = xn ? (~x_raw + CW'(1)) : x_raw;
        ay     = yn ? (~y_raw + CW'(1)) : y_raw;
        ax_ext = (CW + 16)'(ax);
        ay_ext = (CW + 16)'(ay);
        ax_sat = (ax_ext > (CW + 16)'(MAG_MAX)) ? MAG_MAX : ax_ext[MAG_W-1:0];
        ay_sat = (ay_ext > (CW + 16)'(MAG_MAX)) ? MAG_MAX : ay_ext[MAG_W-1:0];

        side_in.xn     = xn;
        side_in.yn     = yn;
        side_in.direct = !(xnz && ynz);
        if (!xnz && !ynz) begin
            side_in.dmag = '0;
            side_in.dang = '0;
        end else if (!ynz) begin
            side_in.dmag = ax_sat;
            side_in.dang = xn ? HALF_UNITS : '0;
        end else begin
            side_in.dmag = ay_sat;
            side_in.dang = yn ? QUARTER_UNITS : (HALF_UNITS + QUARTER_UNITS);
        end
    end

    logic                r_v0;
    logic signed [W-1:0] r_x0, r_y0;
    t_side               r_side0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0    <= W'({ax, {FRAC{1'b0}}});
            r_y0    <= W'({ay, {FRAC{1'b0}}});
            r_side0 <= side_in;
        end
    end

    // ---------------- cordic chain ----------------
    logic                 c_valid [ITERATIONS+1];
    logic signed [W-1:0]  c_x     [ITERATIONS+1];
    logic signed [W-1:0]  c_y     [ITERATIONS+1];
    logic signed [ZW-1:0] c_z     [ITERATIONS+1];
    t_side                c_side  [ITERATIONS+1];

    assign c_valid[0] = r_v0;
    assign c_x[0]     = r_x0;
    assign c_y[0]     = r_y0;
    assign c_z[0]     = '0;
    assign c_side[0]  = r_side0;

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
        vtp_cell #(
            .W     (W),
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[g]),
            .i_x     (c_x[g]),
            .i_y     (c_y[g]),
            .i_z     (c_z[g]),
            .i_side  (c_side[g]),
            .o_valid (c_valid[g+1]),
            .o_x     (c_x[g+1]),
            .o_y     (c_y[g+1]),
            .o_z     (c_z[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    // ---------------- finish ----------------
    logic    fin_valid;
    t_result fin_result;

    vtp_post #(
        .W          (W),
        .ITERATIONS (ITERATIONS)
    ) u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (c_valid[ITERATIONS]),
        .i_x      (c_x[ITERATIONS]),
        .i_z      (c_z[ITERATIONS]),
        .i_side   (c_side[ITERATIONS]),
        .o_valid  (fin_valid),
        .o_result (fin_result)
    );

    // ---------------- output register and skid ----------------
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    assign en = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (fin_valid) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out <= r_skid;
            end
        end else if (fin_valid) begin
            if (!r_out_valid || m_axis_tready) begin
                r_out <= fin_result;
            end else begin
                r_skid <= fin_result;
            end
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - RESULT_W)'(0), r_out};

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready && !r_skid_valid && fin_valid |=> r_skid_valid)
        else $error("finished result lost while output stalled");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !m_axis_tready |=> r_skid_valid && $stable(r_skid))
        else $error("skid result dropped before the output register freed");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.angle < FULL_UNITS) && (r_out.quadrant_code <= QUAD_4))
        else $error("angle or quadrant code out of range");

    a_axis_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.quadrant_code == QUAD_AXIS) |->
            (r_out.angle == '0) || (r_out.angle == QUARTER_UNITS) ||
            (r_out.angle == HALF_UNITS) ||
            (r_out.angle == HALF_UNITS + QUARTER_UNITS))
        else $error("axis vector with an angle off the axes");
`endif

endmodule
